// ===== rtl/core/psi_pkg.sv =====
package psi_pkg;

   // Width of a plane normal component, signed Q1.14.
   localparam int NORMAL_BITS = 16;

   // Control that travels with every pipeline slot.
   typedef struct packed {
      logic valid;
      logic hit;
   } psi_ctrl_type;

endpackage

// ===== rtl/core/psi_ifaces.sv =====
interface psi_req_if #(
   parameter int COORD_BITS = 16
);
   import psi_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  start_x;
   logic signed [COORD_BITS-1:0]  start_y;
   logic signed [COORD_BITS-1:0]  start_z;
   logic signed [COORD_BITS-1:0]  end_x;
   logic signed [COORD_BITS-1:0]  end_y;
   logic signed [COORD_BITS-1:0]  end_z;
   logic signed [NORMAL_BITS-1:0] normal_x;
   logic signed [NORMAL_BITS-1:0] normal_y;
   logic signed [NORMAL_BITS-1:0] normal_z;
   logic signed [COORD_BITS-1:0]  plane_x;
   logic signed [COORD_BITS-1:0]  plane_y;
   logic signed [COORD_BITS-1:0]  plane_z;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z,
             normal_x, normal_y, normal_z, plane_x, plane_y, plane_z,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
             normal_x, normal_y, normal_z, plane_x, plane_y, plane_z,
      output ready
   );
endinterface

interface psi_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic signed [COORD_BITS-1:0] contact_x;
   logic signed [COORD_BITS-1:0] contact_y;
   logic signed [COORD_BITS-1:0] contact_z;

   modport source (
      output valid, hit, contact_x, contact_y, contact_z,
      input  ready
   );

   modport sink (
      input  valid, hit, contact_x, contact_y, contact_z,
      output ready
   );
endinterface

// ===== rtl/core/psi_div_cell.sv =====
// One restoring division step: shifts the partial remainder, subtracts the
// divisor when it fits and appends one quotient bit. The payload rides along.
module psi_div_cell #(
   parameter int DEN_W = 36,
   parameter int Q_W   = 16,
   parameter int PAY_W = 99
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  psi_pkg::psi_ctrl_type ctrl_i,
   input  logic [DEN_W-1:0]     rem_i,
   input  logic [DEN_W-1:0]     den_i,
   input  logic [Q_W-1:0]       q_i,
   input  logic [PAY_W-1:0]     pay_i,
   output psi_pkg::psi_ctrl_type ctrl_o,
   output logic [DEN_W-1:0]     rem_o,
   output logic [DEN_W-1:0]     den_o,
   output logic [Q_W-1:0]       q_o,
   output logic [PAY_W-1:0]     pay_o
);
   import psi_pkg::*;

   psi_ctrl_type     ctrl_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [PAY_W-1:0] pay_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // Trial subtraction of the divisor from the doubled remainder.
   always_comb begin
      rem_sh  = {rem_i, 1'b0};
      rem_sub = rem_sh - {1'b0, den_i};
      fits    = (rem_sh >= {1'b0, den_i});
      rem_in  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_in    = {q_i[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         q_ff   <= q_in;
         pay_ff <= pay_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign q_o    = q_ff;
   assign pay_o  = pay_ff;
endmodule

// ===== rtl/core/psi_contact.sv =====
// Scales the segment direction by t and adds it to the start point.
// Stage one forms the unsigned products t * |d|, stage two floors them
// toward minus infinity and adds the start coordinate.
module psi_contact #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  psi_pkg::psi_ctrl_type       ctrl_i,
   input  logic [T_FRAC_BITS-1:0]      t_i,
   input  logic [3*COORD_BITS-1:0]     start_i,
   input  logic [3*(COORD_BITS+1)-1:0] dse_i,
   output psi_pkg::psi_ctrl_type       ctrl_o,
   output logic [3*COORD_BITS-1:0]     contact_o
);
   import psi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int D  = COORD_BITS + 1;
   localparam int TF = T_FRAC_BITS;
   localparam int PW = TF + C;
   localparam logic [PW-1:0] ROUND_UP = PW'({TF{1'b1}});

   psi_ctrl_type      ctrl1_ff, ctrl2_ff;
   logic [PW-1:0]     prod_ff   [3];
   logic [PW-1:0]     prod_in   [3];
   logic              neg_ff    [3];
   logic [C-1:0]      start1_ff [3];
   logic [C-1:0]      cont_ff   [3];
   logic [C-1:0]      cont_in   [3];

   // Unsigned product of t and the direction magnitude.
   always_comb begin
      logic signed [D-1:0] d;
      logic [C-1:0]        dmag;
      for (int k = 0; k < 3; k++) begin
         d          = dse_i[k*D +: D];
         dmag       = d[D-1] ? C'(-d) : C'(d);
         prod_in[k] = PW'(t_i) * PW'(dmag);
      end
   end

   // Floor of the signed scaled step, then the add to the start point.
   always_comb begin
      logic [C-1:0]          qmag;
      logic signed [C+1:0]   step;
      logic signed [C+1:0]   sum;
      for (int k = 0; k < 3; k++) begin
         if (neg_ff[k]) begin
            qmag = C'((prod_ff[k] + ROUND_UP) >> TF);
            step = -$signed({2'b00, qmag});
         end else begin
            qmag = C'(prod_ff[k] >> TF);
            step = $signed({2'b00, qmag});
         end
         sum        = $signed({{2{start1_ff[k][C-1]}}, start1_ff[k]}) + step;
         cont_in[k] = ctrl1_ff.hit ? sum[C-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else if (adv) begin
         ctrl1_ff <= ctrl_i;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k]   <= prod_in[k];
            neg_ff[k]    <= dse_i[k*D + D - 1];
            start1_ff[k] <= start_i[k*C +: C];
            cont_ff[k]   <= cont_in[k];
         end
      end
   end

   assign ctrl_o = ctrl2_ff;
   for (genvar g = 0; g < 3; g++) begin : g_out
      assign contact_o[g*C +: C] = cont_ff[g];
   end
endmodule

// ===== rtl/core/plane_segment_intersect.sv =====
// Segment against plane intersection in fixed point.
//
// The req channel carries one segment (start, end, signed Q8.8) and one plane
// (normal in signed Q1.14, a point on the plane in Q8.8) per transfer. The rsp
// channel returns one result per request, in order: hit, and the contact
// point in Q8.8, which is zero when hit is clear. A hit needs the two
// endpoints strictly on opposite sides of the plane.
//
// The datapath is a fixed pipeline: input register, products of the normal
// with the offsets, the two signed distances, their magnitudes, then a chain
// of T_FRAC_BITS division cells, each producing one bit of t, then two stages
// that scale the direction by t and add the start point, then the output
// register. One request is taken every cycle while the skid is empty; the
// division chain holds up to T_FRAC_BITS items in flight, so the rate is one
// item per cycle unless the receiver stalls.
//
// Reset clears all valid flags; the block is empty afterwards. When the
// receiver stalls, the next finished result drops into a skid register and
// the whole pipeline, and req.ready, hold until the skid drains.
module plane_segment_intersect #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   psi_req_if.sink   req,
   psi_rsp_if.source rsp
);
   import psi_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int D     = COORD_BITS + 1;
   localparam int TF    = T_FRAC_BITS;
   localparam int PN    = D + NORMAL_BITS;
   localparam int AW    = PN + 2;
   localparam int MW    = AW - 1;
   localparam int DW    = MW + 1;
   localparam int PAY_W = 3 * C + 3 * D;

   logic adv;

   // Input register.
   logic            s0_valid_ff;
   logic [C-1:0]    s_ff [3];
   logic [C-1:0]    e_ff [3];
   logic [NORMAL_BITS-1:0] n_ff [3];
   logic [C-1:0]    p_ff [3];

   // Products of the normal with both offsets.
   logic            s1_valid_ff;
   logic [PN-1:0]   pa_ff [3], pa_in [3];
   logic [PN-1:0]   pb_ff [3], pb_in [3];
   logic [PAY_W-1:0] pay1_ff, pay1_in;

   // Signed distances.
   logic            s2_valid_ff;
   logic [AW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [PAY_W-1:0] pay2_ff;

   // Magnitudes and divisor.
   psi_ctrl_type    s3_ctrl_ff, s3_ctrl_in;
   logic [DW-1:0]   rem3_ff, rem3_in;
   logic [DW-1:0]   den3_ff, den3_in;
   logic [PAY_W-1:0] pay3_ff;

   // Division chain links.
   psi_ctrl_type    ch_ctrl [TF+1];
   logic [DW-1:0]   ch_rem  [TF+1];
   logic [DW-1:0]   ch_den  [TF+1];
   logic [TF-1:0]   ch_q    [TF+1];
   logic [PAY_W-1:0] ch_pay [TF+1];

   psi_ctrl_type    ct_ctrl;
   logic [3*C-1:0]  ct_contact;

   // Output register and skid.
   logic            rsp_valid_ff;
   logic            rsp_hit_ff;
   logic [3*C-1:0]  rsp_cont_ff;
   logic            skid_valid_ff;
   logic            skid_hit_ff;
   logic [3*C-1:0]  skid_cont_ff;

   assign adv       = !skid_valid_ff;
   assign req.ready = adv;

   // Request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ctrl_ff  <= '0;
      end else if (adv) begin
         s0_valid_ff <= req.valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_ctrl_ff  <= s3_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0] <= req.start_x;  s_ff[1] <= req.start_y;  s_ff[2] <= req.start_z;
         e_ff[0] <= req.end_x;    e_ff[1] <= req.end_y;    e_ff[2] <= req.end_z;
         n_ff[0] <= req.normal_x; n_ff[1] <= req.normal_y; n_ff[2] <= req.normal_z;
         p_ff[0] <= req.plane_x;  p_ff[1] <= req.plane_y;  p_ff[2] <= req.plane_z;
      end
   end

   // Offsets from the plane point and the segment direction.
   always_comb begin
      logic signed [D-1:0] ds, de, dse;
      for (int k = 0; k < 3; k++) begin
         ds = $signed({s_ff[k][C-1], s_ff[k]}) - $signed({p_ff[k][C-1], p_ff[k]});
         de = $signed({e_ff[k][C-1], e_ff[k]}) - $signed({p_ff[k][C-1], p_ff[k]});
         dse = $signed({e_ff[k][C-1], e_ff[k]}) - $signed({s_ff[k][C-1], s_ff[k]});
         pa_in[k] = $signed(n_ff[k]) * ds;
         pb_in[k] = $signed(n_ff[k]) * de;
         pay1_in[k*C +: C]       = s_ff[k];
         pay1_in[3*C + k*D +: D] = dse;
      end
   end

   // Sums of the three products.
   always_comb begin
      a_in = AW'($signed(pa_ff[0])) + AW'($signed(pa_ff[1])) + AW'($signed(pa_ff[2]));
      b_in = AW'($signed(pb_ff[0])) + AW'($signed(pb_ff[1])) + AW'($signed(pb_ff[2]));
   end

   // Strict sign test, magnitudes and the divisor |a| + |b|.
   always_comb begin
      logic          a_neg, b_neg, a_pos, b_pos;
      logic [MW-1:0] a_mag, b_mag;
      a_neg = a_ff[AW-1];
      b_neg = b_ff[AW-1];
      a_pos = !a_neg && (a_ff != '0);
      b_pos = !b_neg && (b_ff != '0);
      a_mag = a_neg ? MW'(-a_ff) : MW'(a_ff);
      b_mag = b_neg ? MW'(-b_ff) : MW'(b_ff);
      s3_ctrl_in.valid = s2_valid_ff;
      s3_ctrl_in.hit   = (a_neg && b_pos) || (a_pos && b_neg);
      rem3_in          = {1'b0, a_mag};
      den3_in          = {1'b0, a_mag} + {1'b0, b_mag};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= pa_in[k];
            pb_ff[k] <= pb_in[k];
         end
         pay1_ff <= pay1_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         pay2_ff <= pay1_ff;
         rem3_ff <= rem3_in;
         den3_ff <= den3_in;
         pay3_ff <= pay2_ff;
      end
   end

   // Chain of restoring division cells, one quotient bit each.
   assign ch_ctrl[0] = s3_ctrl_ff;
   assign ch_rem[0]  = rem3_ff;
   assign ch_den[0]  = den3_ff;
   assign ch_q[0]    = '0;
   assign ch_pay[0]  = pay3_ff;

   for (genvar g = 0; g < TF; g++) begin : g_cell
      psi_div_cell #(
         .DEN_W (DW),
         .Q_W   (TF),
         .PAY_W (PAY_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctrl_i (ch_ctrl[g]),
         .rem_i  (ch_rem[g]),
         .den_i  (ch_den[g]),
         .q_i    (ch_q[g]),
         .pay_i  (ch_pay[g]),
         .ctrl_o (ch_ctrl[g+1]),
         .rem_o  (ch_rem[g+1]),
         .den_o  (ch_den[g+1]),
         .q_o    (ch_q[g+1]),
         .pay_o  (ch_pay[g+1])
      );
   end

   // Contact point from t.
   psi_contact #(
      .COORD_BITS  (C),
      .T_FRAC_BITS (TF)
   ) u_contact (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctrl_i    (ch_ctrl[TF]),
      .t_i       (ch_q[TF]),
      .start_i   (ch_pay[TF][3*C-1:0]),
      .dse_i     (ch_pay[TF][PAY_W-1:3*C]),
      .ctrl_o    (ct_ctrl),
      .contact_o (ct_contact)
   );

   // Output register with skid: a result that arrives while the receiver
   // stalls waits in the skid and the pipeline freezes behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp.ready || !rsp_valid_ff) begin
         rsp_valid_ff  <= skid_valid_ff || ct_ctrl.valid;
         skid_valid_ff <= 1'b0;
      end else if (adv && ct_ctrl.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.ready || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_hit_ff  <= skid_hit_ff;
            rsp_cont_ff <= skid_cont_ff;
         end else begin
            rsp_hit_ff  <= ct_ctrl.hit;
            rsp_cont_ff <= ct_contact;
         end
      end else if (adv && ct_ctrl.valid) begin
         skid_hit_ff  <= ct_ctrl.hit;
         skid_cont_ff <= ct_contact;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.contact_x = rsp_cont_ff[0 +: C];
   assign rsp.contact_y = rsp_cont_ff[C +: C];
   assign rsp.contact_z = rsp_cont_ff[2*C +: C];

   // The skid only holds a result behind a waiting output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // The skid fills only on a stalled output.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp.valid && !rsp.ready))
      else $error("skid filled without a receiver stall");

   // No request is taken while the skid is occupied.
   a_no_take_on_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req.ready)
      else $error("request accepted while the skid is full");

   // A miss reports the zero vector.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.hit) |->
         (rsp.contact_x == '0 && rsp.contact_y == '0 && rsp.contact_z == '0))
      else $error("miss with a nonzero contact point");
endmodule
